[hdl/motor_current_sense_filter_core_macros.svh]
// Assertion macros shared by the motor current sense filter RTL.
`ifndef MOTOR_CURRENT_SENSE_FILTER_CORE_MACROS_SVH
`define MOTOR_CURRENT_SENSE_FILTER_CORE_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define MCSF_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mcsf assertion failed");
// Next-cycle implication, disabled during reset.
`define MCSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mcsf assertion failed");
`else
`define MCSF_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define MCSF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[hdl/mcsf_pkg.sv]
// Shared constants, register codes and types of the motor current sense filter.
package mcsf_pkg;

  localparam int MOTORS = 4;

  // Field and datapath widths
  localparam int IDX_W    = 2;
  localparam int SAMPLE_W = 12;
  localparam int CUR_W    = 15;
  localparam int RES_W    = 16;
  localparam int K_W      = 8;
  localparam int UV_W     = 22;
  localparam int MUL_B_W  = 12;
  localparam int PROD_W   = UV_W + MUL_B_W;
  localparam int DIVN_W   = 25;
  localparam int STEP_W   = 5;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  // Conversion constants; 4096 steps is a shift by twelve
  localparam int unsigned FULL_SCALE_UV  = 3300000;
  localparam int          ADC_SHIFT      = 12;
  localparam int unsigned UV_TO_MA_SCALE = 10;
  localparam logic [CUR_W-1:0] SAT_MAX   = '1;

  // Register indexes
  localparam logic [2:0] REG_SENSE_RES_0 = 3'd0;
  localparam logic [2:0] REG_SENSE_RES_1 = 3'd1;
  localparam logic [2:0] REG_SENSE_RES_2 = 3'd2;
  localparam logic [2:0] REG_SENSE_RES_3 = 3'd3;
  localparam logic [2:0] REG_FILTER_K_0  = 3'd4;
  localparam logic [2:0] REG_FILTER_K_1  = 3'd5;
  localparam logic [2:0] REG_FILTER_K_2  = 3'd6;
  localparam logic [2:0] REG_FILTER_K_3  = 3'd7;

  // Request to the shared divider
  typedef struct packed {
    logic              start;
    logic [DIVN_W-1:0] dividend;
    logic [RES_W-1:0]  divisor;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  // Status and result of the shared divider
  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIVN_W-1:0] quotient;
  } div_stat_t;

endpackage

[hdl/mcsf_if.sv]
// Valid/ready channel interfaces for samples and filtered results.
interface mcsf_in_if
  import mcsf_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [IDX_W-1:0]    motor_index;
  logic [SAMPLE_W-1:0] adc_sample;

  modport source (output valid, motor_index, adc_sample, input ready);
  modport sink   (input valid, motor_index, adc_sample, output ready);
endinterface

interface mcsf_out_if
  import mcsf_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] result_motor;
  logic [CUR_W-1:0] current_ma;

  modport source (output valid, result_motor, current_ma, input ready);
  modport sink   (input valid, result_motor, current_ma, output ready);
endinterface

[hdl/mcsf_div.sv]
// Restoring divider, one quotient bit per cycle, shared by all divisions.
module mcsf_div
  import mcsf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  div_req_t  req,
  output div_stat_t stat
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [RES_W-1:0]  rem_r, rem_nxt;
  logic [DIVN_W-1:0] quo_r, quo_nxt;
  logic [RES_W-1:0]  dvs_r, dvs_nxt;

  logic [RES_W:0]    trial;
  logic [RES_W:0]    diff;
  logic              fits;

  // Trial subtract of the divisor from the shifted remainder
  assign trial = {rem_r, quo_r[DIVN_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = trial >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.steps;
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[RES_W-1:0] : trial[RES_W-1:0];
      quo_nxt = {quo_r[DIVN_W-2:0], fits};
      cnt_nxt = cnt_r - STEP_W'(1);
      if (cnt_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign stat.busy     = busy_r;
  assign stat.done     = done_r;
  assign stat.quotient = quo_r;

endmodule

[hdl/motor_current_sense_filter_core.sv]
// One sample is processed at a time: a new sample is taken only after the last result is in the output register.
// Each sample takes 25 + 23 + 15 quotient bits on the shared restoring divider, one per cycle,
// plus three multiply steps on one shared multiplier and the handover cycles.
// A finished result waits in the output register while the next sample is taken.
// Reset (rst_n low, synchronous): accumulators cleared, sense_res and filter_k set to 1,
// output channel empty.
`include "motor_current_sense_filter_core_macros.svh"

module motor_current_sense_filter_core
  import mcsf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  mcsf_in_if.sink           in_if,
  mcsf_out_if.source        out_if,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_UV     = 9'b000000010,
    S_MA10   = 9'b000000100,
    S_DIVMA  = 9'b000001000,
    S_KMUL   = 9'b000010000,
    S_DIVK   = 9'b000100000,
    S_OUTDIV = 9'b001000000,
    S_DIVOUT = 9'b010000000,
    S_FIN    = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [3:0][RES_W-1:0] sense_res_r;
  logic [3:0][K_W-1:0]   filter_k_r;
  logic [3:0][CUR_W-1:0] acc_mem_r, acc_mem_nxt;

  logic [IDX_W-1:0]    motor_r, motor_nxt;
  logic [SAMPLE_W-1:0] sample_r, sample_nxt;
  logic [RES_W-1:0]    res_r, res_nxt;
  logic [K_W-1:0]      k_r, k_nxt;
  logic [CUR_W-1:0]    acc_r, acc_nxt;
  logic [UV_W-1:0]     uv_r, uv_nxt;
  logic [CUR_W-1:0]    ma_r, ma_nxt;
  logic [CUR_W-1:0]    filt_r, filt_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]    out_motor_r, out_motor_nxt;
  logic [CUR_W-1:0]    out_cur_r, out_cur_nxt;

  logic [UV_W-1:0]     mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic [PROD_W-1:0]   mul_p;

  div_req_t            div_req;
  div_stat_t           div_stat;

  logic                in_fire;
  logic                out_fire;
  logic                cfg_wr;
  logic [2:0]          cfg_idx;
  logic [CUR_W:0]      acc_sum;

  // Shared divider
  mcsf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .stat  (div_stat)
  );

  assign in_fire  = in_if.valid && in_if.ready;
  assign out_fire = out_if.valid && out_if.ready;
  assign cfg_wr   = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx  = cfg_paddr[ADDR_W-1:2];

  // Configuration write and read decode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        sense_res_r[i] <= RES_W'(1);
        filter_k_r[i]  <= K_W'(1);
      end
    end else if (cfg_wr) begin
      unique case (cfg_idx) inside
        REG_SENSE_RES_0, REG_SENSE_RES_1, REG_SENSE_RES_2, REG_SENSE_RES_3: begin
          sense_res_r[cfg_idx[1:0]] <= cfg_pwdata[RES_W-1:0];
        end
        REG_FILTER_K_0, REG_FILTER_K_1, REG_FILTER_K_2, REG_FILTER_K_3: begin
          filter_k_r[cfg_idx[1:0]] <= cfg_pwdata[K_W-1:0];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_idx) inside
      REG_SENSE_RES_0, REG_SENSE_RES_1, REG_SENSE_RES_2, REG_SENSE_RES_3: begin
        cfg_prdata = DATA_W'(sense_res_r[cfg_idx[1:0]]);
      end
      REG_FILTER_K_0, REG_FILTER_K_1, REG_FILTER_K_2, REG_FILTER_K_3: begin
        cfg_prdata = DATA_W'(filter_k_r[cfg_idx[1:0]]);
      end
      default: cfg_prdata = '0;
    endcase
  end

  assign cfg_pready = 1'b1;

  // Shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_UV: begin
        mul_a = UV_W'(FULL_SCALE_UV);
        mul_b = sample_r;
      end
      S_MA10: begin
        mul_a = uv_r;
        mul_b = MUL_B_W'(UV_TO_MA_SCALE);
      end
      S_KMUL: begin
        mul_a = UV_W'(acc_r);
        mul_b = MUL_B_W'(k_r - K_W'(1));
      end
      default: ;
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Accumulator update: decayed value plus raw current
  assign acc_sum = {1'b0, div_stat.quotient[CUR_W-1:0]} + {1'b0, ma_r};

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    motor_nxt     = motor_r;
    sample_nxt    = sample_r;
    res_nxt       = res_r;
    k_nxt         = k_r;
    acc_nxt       = acc_r;
    uv_nxt        = uv_r;
    ma_nxt        = ma_r;
    filt_nxt      = filt_r;
    acc_mem_nxt   = acc_mem_r;
    out_valid_nxt = out_valid_r;
    out_motor_nxt = out_motor_r;
    out_cur_nxt   = out_cur_r;
    div_req       = '0;

    // Drop the output once taken
    if (out_fire) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          motor_nxt  = in_if.motor_index;
          sample_nxt = in_if.adc_sample;
          res_nxt    = (sense_res_r[in_if.motor_index] == '0) ? RES_W'(1)
                                                              : sense_res_r[in_if.motor_index];
          k_nxt      = (filter_k_r[in_if.motor_index] == '0) ? K_W'(1)
                                                            : filter_k_r[in_if.motor_index];
          acc_nxt    = acc_mem_r[in_if.motor_index];
          if (32'(in_if.motor_index) >= MOTORS) begin
            filt_nxt  = '0;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_UV;
          end
        end
      end
      S_UV: begin
        uv_nxt    = mul_p[PROD_W-1:ADC_SHIFT];
        state_nxt = S_MA10;
      end
      S_MA10: begin
        div_req.start    = 1'b1;
        div_req.dividend = mul_p[DIVN_W-1:0];
        div_req.divisor  = res_r;
        div_req.steps    = STEP_W'(DIVN_W);
        state_nxt        = S_DIVMA;
      end
      S_DIVMA: begin
        if (div_stat.done) begin
          ma_nxt    = (|div_stat.quotient[DIVN_W-1:CUR_W]) ? SAT_MAX
                                                           : div_stat.quotient[CUR_W-1:0];
          state_nxt = S_KMUL;
        end
      end
      S_KMUL: begin
        div_req.start    = 1'b1;
        div_req.dividend = {mul_p[CUR_W+K_W-1:0], (DIVN_W-CUR_W-K_W)'(0)};
        div_req.divisor  = RES_W'(k_r);
        div_req.steps    = STEP_W'(CUR_W + K_W);
        state_nxt        = S_DIVK;
      end
      S_DIVK: begin
        if (div_stat.done) begin
          acc_nxt                  = acc_sum[CUR_W] ? SAT_MAX : acc_sum[CUR_W-1:0];
          acc_mem_nxt[motor_r]     = acc_nxt;
          state_nxt                = S_OUTDIV;
        end
      end
      S_OUTDIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = {acc_r, (DIVN_W-CUR_W)'(0)};
        div_req.divisor  = RES_W'(k_r);
        div_req.steps    = STEP_W'(CUR_W);
        state_nxt        = S_DIVOUT;
      end
      S_DIVOUT: begin
        if (div_stat.done) begin
          filt_nxt  = div_stat.quotient[CUR_W-1:0];
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // Hold until the output register is free
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          out_motor_nxt = motor_r;
          out_cur_nxt   = filt_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state and accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      acc_mem_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      acc_mem_r   <= acc_mem_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    motor_r     <= motor_nxt;
    sample_r    <= sample_nxt;
    res_r       <= res_nxt;
    k_r         <= k_nxt;
    acc_r       <= acc_nxt;
    uv_r        <= uv_nxt;
    ma_r        <= ma_nxt;
    filt_r      <= filt_nxt;
    out_motor_r <= out_motor_nxt;
    out_cur_r   <= out_cur_nxt;
  end

  assign in_if.ready         = (state_r == S_IDLE);
  assign out_if.valid        = out_valid_r;
  assign out_if.result_motor = out_motor_r;
  assign out_if.current_ma   = out_cur_r;

  // Never restart the divider mid-division
  `MCSF_ASSERT_IMPLIES(a_div_no_restart, clk, rst_n, div_req.start, !div_stat.busy)
  // A divide-wait state always has a division running or just finished
  `MCSF_ASSERT_IMPLIES(a_div_wait_live, clk, rst_n,
    (state_r == S_DIVMA) || (state_r == S_DIVK) || (state_r == S_DIVOUT),
    div_stat.busy || div_stat.done)
  // Accumulators change only at the filter update
  `MCSF_ASSERT_NEXT(a_acc_hold, clk, rst_n,
    !((state_r == S_DIVK) && div_stat.done), $stable(acc_mem_r))

endmodule
